// ===== design/emg_exponential_activation_unit_assert.svh =====
// Assertion macros shared by the EMG activation unit RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef EMG_EXPONENTIAL_ACTIVATION_UNIT_ASSERT_SVH
`define EMG_EXPONENTIAL_ACTIVATION_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define EMG_EA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define EMG_EA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/emg_ea_pkg.sv =====
// Shared types, constants and ROM helper functions for the EMG activation unit.
// No dependencies; used by the controller, datapath and top level.
package emg_ea_pkg;

  // exponential unit fraction width
  localparam int unsigned EXP_FRAC = 32;
  localparam logic [63:0] LN2_Q62  = 64'h2C5C_85FD_F473_DE6B;
  localparam logic [31:0] LN2_Q32  = LN2_Q62[61:30];
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  // floor(v/3) = (v * RECIP3) >> 33 for any 32-bit v
  localparam logic [31:0] RECIP3   = 32'hAAAA_AAAB;
  localparam int unsigned DIV_STEPS = 17;

  // configuration register indexes
  localparam logic [1:0] CFG_COEF_C1 = 2'd0;
  localparam logic [1:0] CFG_COEF_C2 = 2'd1;
  localparam logic [1:0] CFG_SHAPE   = 2'd2;

  typedef struct packed {
    logic        command;
    logic [15:0] emg_sample;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        activation;
    logic signed [19:0] neural_activation;
    logic               clipped;
  } out_word_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE, OP_A, OP_ACC1, OP_ACC2, OP_ACC3, OP_ROUND,
    OP_XMUL, OP_MAG, OP_YM, OP_TSPL, OP_FRAC, OP_W,
    OP_T2, OP_T3A, OP_T3B, OP_T4, OP_P, OP_SHIFT,
    OP_DSET, OP_DCHK, OP_DOVF, OP_DIV, OP_DFIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   exp_sel;   // 0: exp(A*u), 1: exp(A)
    logic   take;      // sample word accepted
    logic   clear;     // clear word accepted
    logic   out_load;  // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic need_exp;
  } dp_status_t;

  // truncating division by a small constant, elaboration use only
  function automatic logic [63:0] div_small(input logic [63:0] v, input int unsigned k);
    logic [63:0] r;
    case (k)
      1:  r = v;
      2:  r = v / 2;
      3:  r = v / 3;
      4:  r = v / 4;
      5:  r = v / 5;
      6:  r = v / 6;
      7:  r = v / 7;
      8:  r = v / 8;
      9:  r = v / 9;
      10: r = v / 10;
      11: r = v / 11;
      12: r = v / 12;
      13: r = v / 13;
      14: r = v / 14;
      15: r = v / 15;
      16: r = v / 16;
      default: r = v;
    endcase
    return r;
  endfunction

  // ROM entry 2^(idx/depth) in Q.32, 16-term Taylor sum, truncating each step
  function automatic logic [32:0] exp_rom_entry(input int unsigned idx, input int unsigned lg);
    logic [127:0] w;
    logic [127:0] term;
    logic [127:0] sum;
    logic [127:0] prod;
    int unsigned  k;
    w    = (128'(idx) * 128'(LN2_Q32)) >> lg;
    term = 128'(1) << EXP_FRAC;
    sum  = term;
    for (k = 1; k <= 16; k++) begin
      prod = (term * w) >> EXP_FRAC;
      term = 128'(div_small(prod[63:0], k));
      sum  = sum + term;
    end
    return sum[32:0];
  endfunction

endpackage

// ===== design/emg_exponential_activation_unit.sv =====
// When no exponential is needed (u negative, u >= 1 or A = 0) the filter result
// is output; otherwise two exponentials and a division follow. One shared 34x34
// multiplier and a 17-step restoring divider do the work. The next word is taken
// in the cycle after the result is loaded; a clear word gives no result.
// Reset (async, active low) zeroes control, config, history and sample count.
// Top level: ties the sequencer (emg_ea_ctrl) to the datapath (emg_ea_datapath).
module emg_exponential_activation_unit import emg_ea_pkg::*; #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  emg_ea_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_command_i (in_word_i.command),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // arithmetic and storage
  emg_ea_datapath #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== design/emg_ea_ctrl.sv =====
// Sequencer for the EMG activation unit: handshakes and micro-op schedule.
// Depends on emg_ea_pkg and the assertion macro header.
`include "emg_exponential_activation_unit_assert.svh"

module emg_ea_ctrl import emg_ea_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_command_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_A, S_ACC1, S_ACC2, S_ACC3, S_ROUND, S_DECIDE,
    S_XMUL, S_MAG, S_YM, S_TSPL, S_FRAC, S_W, S_T2, S_T3A, S_T3B,
    S_T4, S_P, S_SHIFT, S_DSET, S_DCHK, S_DOVF, S_DIV, S_DFIN, S_OUT
  } state_e;

  state_e      state_q, state_d;
  dp_op_e      op_q, op_d;
  logic        sel_q, sel_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic        take, clear, out_load;

  // micro-op issued while in each state
  function automatic dp_op_e op_of(input state_e s);
    dp_op_e o;
    unique case (s)
      S_A:     o = OP_A;
      S_ACC1:  o = OP_ACC1;
      S_ACC2:  o = OP_ACC2;
      S_ACC3:  o = OP_ACC3;
      S_ROUND: o = OP_ROUND;
      S_XMUL:  o = OP_XMUL;
      S_MAG:   o = OP_MAG;
      S_YM:    o = OP_YM;
      S_TSPL:  o = OP_TSPL;
      S_FRAC:  o = OP_FRAC;
      S_W:     o = OP_W;
      S_T2:    o = OP_T2;
      S_T3A:   o = OP_T3A;
      S_T3B:   o = OP_T3B;
      S_T4:    o = OP_T4;
      S_P:     o = OP_P;
      S_SHIFT: o = OP_SHIFT;
      S_DSET:  o = OP_DSET;
      S_DCHK:  o = OP_DCHK;
      S_DOVF:  o = OP_DOVF;
      S_DIV:   o = OP_DIV;
      S_DFIN:  o = OP_DFIN;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d  = state_q;
    sel_d    = sel_q;
    cnt_d    = cnt_q;
    take     = 1'b0;
    clear    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_command_i) begin
            clear = 1'b1;
          end else begin
            take    = 1'b1;
            state_d = S_A;
          end
        end
      end
      S_A:     state_d = S_ACC1;
      S_ACC1:  state_d = S_ACC2;
      S_ACC2:  state_d = S_ACC3;
      S_ACC3:  state_d = S_ROUND;
      S_ROUND: state_d = S_DECIDE;
      S_DECIDE: begin
        if (status_i.need_exp) begin
          state_d = S_XMUL;
          sel_d   = 1'b0;
        end else begin
          state_d = S_OUT;
        end
      end
      S_XMUL:  state_d = S_MAG;
      S_MAG:   state_d = S_YM;
      S_YM:    state_d = S_TSPL;
      S_TSPL:  state_d = S_FRAC;
      S_FRAC:  state_d = S_W;
      S_W:     state_d = S_T2;
      S_T2:    state_d = S_T3A;
      S_T3A:   state_d = S_T3B;
      S_T3B:   state_d = S_T4;
      S_T4:    state_d = S_P;
      S_P:     state_d = S_SHIFT;
      S_SHIFT: begin
        if (!sel_q) begin
          state_d = S_XMUL;
          sel_d   = 1'b1;
        end else begin
          state_d = S_DSET;
        end
      end
      S_DSET:  state_d = S_DCHK;
      S_DCHK:  state_d = S_DOVF;
      S_DOVF: begin
        state_d = S_DIV;
        cnt_d   = 5'(DIV_STEPS - 1);
      end
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = S_DFIN;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_DFIN:  state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    op_d = op_of(state_d);
  end

  // output register occupancy
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state and registered command outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      sel_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      sel_q       <= sel_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o = '{op: op_q, exp_sel: sel_q, take: take, clear: clear, out_load: out_load};

  `EMG_EA_ASSERT_NXT(a_take_starts_filter, take, (state_q == S_A) && (op_q == OP_A), "take did not start filter")
  `EMG_EA_ASSERT_IMP(a_div_length, state_q == S_DFIN, ($past(state_q, 17) == S_DIV) && ($past(state_q, 18) == S_DOVF), "divider ran wrong number of steps")
  `EMG_EA_ASSERT_IMP(a_both_exps_done, state_q == S_DSET, sel_q && ($past(state_q) == S_SHIFT), "division started before both exponentials")

endmodule

// ===== design/emg_ea_datapath.sv =====
// Datapath of the EMG activation unit: config, history, filter, exp unit, divider.
// Depends on emg_ea_pkg; driven by emg_ea_ctrl through dp_cmd_t.
module emg_ea_datapath import emg_ea_pkg::*; #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  in_word_t    in_word_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  output out_word_t   out_word_o
);

  localparam int unsigned RomAw = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned FlowW = EXP_FRAC - RomAw;

  // 2^(i/depth) table, constant logic
  logic [32:0] rom_tbl [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign rom_tbl[g] = exp_rom_entry(g, RomAw);
  end

  // config and history
  logic signed [15:0] c1_q, c2_q, shape_q;
  logic signed [19:0] u1_q, u2_q;
  logic [15:0]        e1_q, e2_q;
  logic [1:0]         cnt_q;
  logic               need_exp_q;

  // working registers
  logic [15:0]        e_q;
  logic signed [16:0] b1_q;
  logic signed [31:0] b2_q;
  logic signed [33:0] a_q;
  logic signed [55:0] acc_q;
  logic signed [19:0] u_q;
  logic [15:0]        act_q;
  logic               clip_q;
  logic signed [67:0] mul_q;
  logic               neg_q;
  logic [31:0]        mag_q;
  logic signed [4:0]  n_q;
  logic [31:0]        f_q;
  logic [32:0]        rom_q;
  logic [31:0]        w_q;
  logic [32:0]        sum_q;
  logic [40:0]        ex_q, ea_q;
  logic [40:0]        num_q, den_q;
  logic               den_zero_q;
  logic [57:0]        r_q, dv_q;
  logic [16:0]        q_q;
  logic               ovf_q;
  out_word_t          out_q;

  // combinational helpers
  logic signed [33:0] ma, mb;
  logic signed [33:0] a_w;
  logic signed [55:0] rnd;
  logic signed [27:0] us;
  logic signed [19:0] usat;
  logic               usat_clip, u_neg, u_big;
  logic signed [33:0] xv;
  logic [33:0]        ax;
  logic [31:0]        mag_w;
  logic [34:0]        ym;
  logic [35:0]        t_w;
  logic [31:0]        t2, t3;
  logic [29:0]        t4;
  logic [40:0]        pw, sh_w;
  logic [3:0]         nneg;
  logic [40:0]        num_w, den_w;
  logic               ge;
  logic [15:0]        mean;

  assign mean = 16'(({1'b0, e1_q} + {1'b0, e2_q}) >> 1);

  // filter gain a = 1 + b1 + b2 in Q.28, b2 taken from the product
  assign a_w = 34'sd268435456 + (34'(b1_q) <<< 14) + 34'($signed(mul_q[31:0]));

  // round half up to Q.16 and saturate
  assign rnd = acc_q + 56'sd134217728;
  assign us  = rnd[55:28];
  always_comb begin
    usat_clip = 1'b0;
    if (us > 28'sd524287) begin
      usat      = 20'sh7FFFF;
      usat_clip = 1'b1;
    end else if (us < -28'sd524288) begin
      usat      = 20'sh80000;
      usat_clip = 1'b1;
    end else begin
      usat = us[19:0];
    end
  end
  assign u_neg = usat[19];
  assign u_big = !usat[19] && (usat[18:16] != 3'd0);

  // exponent magnitude, clamped to 2^31
  assign xv    = $signed(mul_q[33:0]);
  assign ax    = xv[33] ? 34'(-xv) : xv;
  assign mag_w = (ax > 34'h0_8000_0000) ? 32'h8000_0000 : ax[31:0];

  // y = |x|*log2(e), offset by 8 so the integer part stays positive
  assign ym  = mul_q[61:27];
  assign t_w = neg_q ? (36'h8_0000_0000 - 36'(ym)) : (36'h8_0000_0000 + 36'(ym));

  // Taylor terms
  assign t2 = {1'b0, mul_q[63:33]};
  assign t3 = mul_q[64:33];
  assign t4 = mul_q[63:34];

  // 2^n scaling of the product
  assign pw   = 41'(mul_q[65:32]);
  assign nneg = 4'(-n_q);
  assign sh_w = n_q[4] ? (pw >> nneg) : (pw << n_q[2:0]);

  // |exp - 1|
  assign num_w = (ex_q >= 41'h1_0000_0000) ? (ex_q - 41'h1_0000_0000)
                                            : (41'h1_0000_0000 - ex_q);
  assign den_w = (ea_q >= 41'h1_0000_0000) ? (ea_q - 41'h1_0000_0000)
                                            : (41'h1_0000_0000 - ea_q);

  assign ge = (r_q >= dv_q);

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd_i.take) begin
      ma = 34'(c1_q);
      mb = 34'(c2_q);
    end else begin
      case (cmd_i.op)
        OP_A: begin
          ma = 34'(b1_q);
          mb = 34'(u1_q);
        end
        OP_ACC1: begin
          ma = a_q;
          mb = 34'(e_q);
        end
        OP_ACC2: begin
          ma = 34'(b2_q);
          mb = 34'(u2_q);
        end
        OP_XMUL: begin
          ma = 34'(shape_q);
          mb = cmd_i.exp_sel ? 34'd65536 : 34'(u_q[15:0]);
        end
        OP_YM: begin
          ma = 34'(mag_q);
          mb = 34'(LOG2E_Q30);
        end
        OP_FRAC: begin
          ma = 34'(f_q[FlowW-1:0]);
          mb = 34'(LN2_Q32);
        end
        OP_W: begin
          ma = 34'(mul_q[63:32]);
          mb = 34'(mul_q[63:32]);
        end
        OP_T2: begin
          ma = 34'(t2);
          mb = 34'(w_q);
        end
        OP_T3A: begin
          ma = 34'(mul_q[63:32]);
          mb = 34'(RECIP3);
        end
        OP_T3B: begin
          ma = 34'(t3);
          mb = 34'(w_q);
        end
        OP_P: begin
          ma = 34'(rom_q);
          mb = 34'(sum_q);
        end
        default: begin
          ma = '0;
          mb = '0;
        end
      endcase
    end
  end

  // config, history and status flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q       <= '0;
      c2_q       <= '0;
      shape_q    <= '0;
      u1_q       <= '0;
      u2_q       <= '0;
      e1_q       <= '0;
      e2_q       <= '0;
      cnt_q      <= '0;
      need_exp_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COEF_C1: c1_q    <= cfg_wdata_i;
          CFG_COEF_C2: c2_q    <= cfg_wdata_i;
          CFG_SHAPE:   shape_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        u1_q  <= '0;
        u2_q  <= '0;
        e1_q  <= '0;
        e2_q  <= '0;
        cnt_q <= '0;
      end else if (cmd_i.take) begin
        // third sample since clear: seed filter with mean of the first two
        if (cnt_q == 2'd2) begin
          u1_q <= 20'(mean);
          u2_q <= 20'(mean);
        end
      end else if (cmd_i.op == OP_ROUND) begin
        u2_q       <= u1_q;
        u1_q       <= usat;
        e2_q       <= e1_q;
        e1_q       <= e_q;
        cnt_q      <= (cnt_q == 2'd3) ? cnt_q : cnt_q + 2'd1;
        need_exp_q <= !u_neg && !u_big && (shape_q != 16'sd0);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mul_q <= ma * mb;
    if (cmd_i.take) begin
      e_q  <= in_word_i.emg_sample;
      b1_q <= 17'(c1_q) + 17'(c2_q);
    end
    if (cmd_i.out_load) begin
      out_q <= '{activation: act_q, neural_activation: u_q, clipped: clip_q};
    end
    case (cmd_i.op)
      OP_A: begin
        a_q  <= a_w;
        b2_q <= $signed(mul_q[31:0]);
      end
      OP_ACC1: acc_q <= -(56'(mul_q) <<< 14);
      OP_ACC2: acc_q <= acc_q + 56'(mul_q);
      OP_ACC3: acc_q <= acc_q - 56'(mul_q);
      OP_ROUND: begin
        u_q <= usat;
        if (u_neg) begin
          act_q  <= '0;
          clip_q <= 1'b1;
        end else if (u_big) begin
          act_q  <= 16'hFFFF;
          clip_q <= 1'b1;
        end else begin
          act_q  <= usat[15:0];
          clip_q <= usat_clip;
        end
      end
      OP_MAG: begin
        mag_q <= mag_w;
        neg_q <= xv[33];
      end
      OP_TSPL: begin
        n_q <= $signed({1'b0, t_w[35:32]}) - 5'sd8;
        f_q <= t_w[31:0];
      end
      OP_FRAC: rom_q <= rom_tbl[f_q[EXP_FRAC-1 -: RomAw]];
      OP_W: begin
        w_q   <= mul_q[63:32];
        sum_q <= 33'h1_0000_0000 + 33'(mul_q[63:32]);
      end
      OP_T2:  sum_q <= sum_q + 33'(t2);
      OP_T3B: sum_q <= sum_q + 33'(t3);
      OP_T4:  sum_q <= sum_q + 33'(t4);
      OP_SHIFT: begin
        if (cmd_i.exp_sel) begin
          ea_q <= sh_w;
        end else begin
          ex_q <= sh_w;
        end
      end
      OP_DSET: begin
        num_q      <= num_w;
        den_q      <= den_w;
        den_zero_q <= (den_w == '0);
      end
      OP_DCHK: begin
        r_q  <= ({1'b0, num_q, 16'h0000}) + 58'(den_q >> 1);
        dv_q <= 58'(den_q) << 16;
      end
      OP_DOVF: begin
        ovf_q <= (r_q >= {dv_q[56:0], 1'b0});
        q_q   <= '0;
      end
      OP_DIV: begin
        if (ge) begin
          r_q <= r_q - dv_q;
        end
        q_q  <= {q_q[15:0], ge};
        dv_q <= dv_q >> 1;
      end
      OP_DFIN: begin
        if (den_zero_q) begin
          act_q <= u_q[15:0];
        end else if (ovf_q || q_q[16]) begin
          act_q  <= 16'hFFFF;
          clip_q <= 1'b1;
        end else begin
          act_q <= q_q[15:0];
        end
      end
      default: ;
    endcase
  end

  assign status_o   = '{need_exp: need_exp_q};
  assign out_word_o = out_q;

endmodule

// ===== sim/emg_ea_checker.sv =====
// Checker for the EMG activation unit: watches the config port and both word
// channels, predicts each result and compares it. Depends on emg_ea_pkg.
module emg_ea_checker import emg_ea_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        err_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ROM_DEPTH = 256;
  localparam logic [63:0] ONE_Q32   = 64'd1 << 32;
  localparam logic [63:0] LN2_FIX   = LN2_Q62 >> 30;

  logic [63:0] exp_table [ROM_DEPTH];
  out_word_t   expected_q [$];

  // filter history and registers
  logic signed [15:0] c1, c2, shape;
  longint             u_prev1, u_prev2;
  logic [15:0]        e_prev1, e_prev2;
  int                 n_seen;

  // floor(a*b / 2^s), low 64 bits
  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] taylor_sum(input logic [63:0] w, input int terms);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = ONE_Q32;
    term = ONE_Q32;
    for (int k = 1; k <= terms; k++) begin
      term = mul_shift(term, w, 32) / 64'(k);
      sum  = sum + term;
    end
    return sum;
  endfunction

  // exp(x) as 2^(x*log2 e): shift for integer part, table times short series for fraction
  function automatic logic [63:0] exp_fixed(input longint x);
    logic [63:0] mag, ym, t, f, fd, idx, rem, w, p;
    int          n;
    mag = (x < 0) ? 64'(-x) : 64'(x);
    if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
    ym  = (mag * 64'(LOG2E_Q30)) >> 27;
    t   = (x < 0) ? (64'd8 << 32) - ym : (64'd8 << 32) + ym;
    n   = int'(t >> 32) - 8;
    f   = t & (ONE_Q32 - 1);
    fd  = f * ROM_DEPTH;
    idx = fd >> 32;
    if (idx >= ROM_DEPTH) idx = ROM_DEPTH - 1;
    rem = fd & (ONE_Q32 - 1);
    w   = mul_shift(rem / ROM_DEPTH, LN2_FIX, 32);
    p   = mul_shift(exp_table[idx], taylor_sum(w, 4), 32);
    return (n >= 0) ? (p << n) : (p >> (-n));
  endfunction

  function automatic out_word_t predict_activation(input logic [15:0] e);
    longint      b1, b2, a, acc, u;
    logic [63:0] act, ex, ea, num, den;
    logic        clip;
    out_word_t   r;
    clip = 1'b0;
    // third sample: seed history with mean of the two earlier samples
    if (n_seen == 2) begin
      u_prev1 = longint'((32'(e_prev1) + 32'(e_prev2)) >> 1);
      u_prev2 = u_prev1;
    end
    b1  = longint'(c1) + longint'(c2);
    b2  = longint'(c1) * longint'(c2);
    a   = (longint'(1) << 28) + b1 * 16384 + b2;
    acc = a * longint'(e) - b1 * u_prev1 * 16384 - b2 * u_prev2;
    u   = (acc + (longint'(1) << 27)) >>> 28;
    if (u > 524287) begin u = 524287; clip = 1'b1; end
    if (u < -524288) begin u = -524288; clip = 1'b1; end
    if (u < 0) begin
      act = 0; clip = 1'b1;
    end else if (u >= 65536) begin
      act = 65535; clip = 1'b1;
    end else if (shape == 0) begin
      act = 64'(u);
    end else begin
      ex  = exp_fixed(longint'(shape) * u);
      ea  = exp_fixed(longint'(shape) * 65536);
      num = (ex >= ONE_Q32) ? ex - ONE_Q32 : ONE_Q32 - ex;
      den = (ea >= ONE_Q32) ? ea - ONE_Q32 : ONE_Q32 - ea;
      if (den == 0) act = 64'(u);
      else act = ((num << 16) + den / 2) / den;
      if (act > 65535) begin act = 65535; clip = 1'b1; end
    end
    u_prev2 = u_prev1;
    u_prev1 = u;
    e_prev2 = e_prev1;
    e_prev1 = e;
    if (n_seen < 3) n_seen++;
    r.activation        = act[15:0];
    r.neural_activation = 20'(u);
    r.clipped           = clip;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < ROM_DEPTH; i++)
      exp_table[i] = taylor_sum((64'(i) * LN2_FIX) / ROM_DEPTH, 16);
  end

  assign pending_o = expected_q.size();

  // watch config, input and output channels
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      c1 = 0; c2 = 0; shape = 0;
      u_prev1 = 0; u_prev2 = 0; e_prev1 = 0; e_prev2 = 0; n_seen = 0;
      expected_q.delete();
      err_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COEF_C1: c1 = cfg_wdata_i;
          CFG_COEF_C2: c2 = cfg_wdata_i;
          CFG_SHAPE:   shape = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word_i);
          err_count_o <= err_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_word_i) begin
            $display("%0t: mismatch exp act=%0d u=%0d clip=%0b got act=%0d u=%0d clip=%0b",
                     $time, want.activation, want.neural_activation, want.clipped,
                     out_word_i.activation, out_word_i.neural_activation,
                     out_word_i.clipped);
            err_count_o <= err_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_word_i.command) begin
          u_prev1 = 0; u_prev2 = 0; e_prev1 = 0; e_prev2 = 0; n_seen = 0;
        end else begin
          expected_q.push_back(predict_activation(in_word_i.emg_sample));
        end
      end
    end
  end

endmodule

// ===== sim/tb_emg_exponential_activation_unit.sv =====
// Testbench top for the EMG activation unit: clock, reset, config writes and
// word traffic with random idling. Depends on emg_ea_pkg and emg_ea_checker.
module tb_emg_exponential_activation_unit import emg_ea_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit CMD_SAMPLE = 1'b0;
  localparam bit CMD_CLEAR  = 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_word_t   out_word_o;
  int          err_count;
  int          pending;
  bit          quiet;
  bit          hold_req;

  emg_exponential_activation_unit u_top (.*);

  emg_ea_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_word_i(out_word_o),
    .err_count_o(err_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = 400;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  // offer one word and return at the edge that accepts it
  task automatic send_word(input bit cmd, input logic [15:0] sample);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    in_word_i.command    <= cmd;
    in_word_i.emg_sample <= sample;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // wait for all results, plus slack for a trailing clear
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [15:0] k1, input logic [15:0] k2,
                           input logic [15:0] a);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_COEF_C1; cfg_wdata_i <= k1;
    @(negedge clk_i);
    cfg_idx_i <= CFG_COEF_C2; cfg_wdata_i <= k2;
    @(negedge clk_i);
    cfg_idx_i <= CFG_SHAPE; cfg_wdata_i <= a;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(5))
      0: return 16'hFFFF;
      1: return 16'(  $urandom_range(255));
      2: return 16'(  $urandom_range(65535, 60000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_words(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) send_word(CMD_CLEAR, 16'($urandom));
      else send_word(CMD_SAMPLE, pick_sample());
    end
  endtask

  initial begin
    logic [15:0] dir_samples [12];
    dir_samples = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
                    16'h7FFF, 16'h4000, 16'h0100, 16'hFFFE, 16'h1234, 16'hC000};
    quiet       = 1'b0;
    hold_req    = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_COEF_C1;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    rst_ni      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: shape zero, then a typical filter with history seeding
    foreach (dir_samples[i]) send_word(CMD_SAMPLE, dir_samples[i]);
    write_cfg(-16'sd8192, -16'sd4096, -16'sd12288);
    send_word(CMD_CLEAR, 16'hFFFF);
    foreach (dir_samples[i]) send_word(CMD_SAMPLE, dir_samples[i]);

    // extremes and typical settings
    write_cfg(16'h8000, 16'h7FFF, -16'sd24576);
    random_words(70);
    write_cfg(16'h7FFF, 16'h7FFF, 16'hFFFF);
    random_words(70);
    write_cfg(-16'sd11000, -16'sd6000, -16'sd16384);
    quiet = 1'b1;
    random_words(60);
    quiet = 1'b0;
    hold_req = 1'b1;
    random_words(40);
    write_cfg(16'($urandom), 16'($urandom), 16'h7FFF);
    random_words(60);
    write_cfg(16'h8000, 16'h8000, 16'h8000);
    random_words(60);
    write_cfg(-16'sd14000, -16'sd3000, -16'sd8192);
    random_words(80);
    write_cfg(16'd0, 16'd0, 16'd0);
    random_words(70);

    drain();
    if (err_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/emg_ea_pkg.sv
design/emg_ea_ctrl.sv
design/emg_ea_datapath.sv
design/emg_exponential_activation_unit.sv
sim/emg_ea_checker.sv
sim/tb_emg_exponential_activation_unit.sv
